### hw/rtl/gsw_pkg.sv
package gsw_pkg;

  localparam int DIST_FRAC_BITS_DEF = 12;
  localparam int QUEUE_DEPTH_DEF    = 2;
  localparam logic [31:0] INV_SPACING_RST = 32'd65536;
  localparam int NUM_AXES = 3;

  typedef enum logic [1:0] {
    REG_INNER,
    REG_MID,
    REG_OUTER,
    REG_ZERO
  } region_t;

  typedef struct packed {
    region_t     region;
    logic [15:0] sq_op;
    logic [15:0] w_mid;
    logic [16:0] gmag;
    logic        gneg;
  } axis_t;

  typedef struct packed {
    axis_t [NUM_AXES-1:0] ax;
    logic                 node_valid;
    logic                 last;
  } item_t;

endpackage

### hw/rtl/gsw_front.sv
module gsw_front #(
  parameter int DIST_FRAC_BITS = gsw_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                q_full,
  input  logic signed [15:0]  in_dist_x,
  input  logic signed [15:0]  in_dist_y,
  input  logic signed [15:0]  in_dist_z,
  input  logic                in_node_valid,
  input  logic                in_last_node,
  output logic                push,
  output gsw_pkg::item_t      push_item
);

  localparam int ONE  = 1 << DIST_FRAC_BITS;
  localparam int QTR  = 1 << (DIST_FRAC_BITS - 2);
  localparam int LIM  = (1249 * ONE + 999) / 1000;
  localparam int GOUT = 5 * (1 << (DIST_FRAC_BITS - 1));
  localparam int GSH  = 16 - DIST_FRAC_BITS;

  logic        accept;
  logic        front_v_r, front_v_nxt;
  logic [15:0] dist_r [gsw_pkg::NUM_AXES];
  logic        node_valid_r;
  logic        last_r;

  function automatic gsw_pkg::axis_t classify(input logic [15:0] raw);
    gsw_pkg::axis_t ax;
    logic [15:0]    a;
    logic [17:0]    gex;
    a         = raw[15] ? 16'(~raw + 16'd1) : raw;
    ax        = '0;
    ax.region = gsw_pkg::REG_ZERO;
    ax.gneg   = ~raw[15];
    gex       = '0;
    if (a < 16'(QTR)) begin
      ax.region = gsw_pkg::REG_INNER;
      ax.sq_op  = a;
      gex       = 18'(a) << 2;
    end else if (a < 16'(3 * QTR)) begin
      ax.region = gsw_pkg::REG_MID;
      ax.w_mid  = 16'((18'(ONE) - 18'(a)) << GSH);
      gex       = 18'(ONE);
    end else if (a < 16'(LIM)) begin
      ax.region = gsw_pkg::REG_OUTER;
      ax.sq_op  = 16'(18'(5 * QTR) - 18'(a));
      gex       = 18'(GOUT) - (18'(a) << 1);
    end
    ax.gmag = 17'(gex << GSH);
    return ax;
  endfunction

  assign accept = start & ~q_full;
  assign push   = front_v_r & ~q_full;

  always_comb begin
    front_v_nxt = front_v_r;
    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (push) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dist_r[0]    <= in_dist_x;
      dist_r[1]    <= in_dist_y;
      dist_r[2]    <= in_dist_z;
      node_valid_r <= in_node_valid;
      last_r       <= in_last_node;
    end
  end

  always_comb begin
    for (int i = 0; i < gsw_pkg::NUM_AXES; i++) begin
      push_item.ax[i] = classify(dist_r[i]);
    end
    push_item.node_valid = node_valid_r;
    push_item.last       = last_r;
  end

endmodule

### hw/rtl/gsw_queue.sv
module gsw_queue #(
  parameter int DEPTH = gsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gsw_pkg::item_t push_item,
  output logic           full,
  output logic           pop_valid,
  output gsw_pkg::item_t pop_item
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gsw_pkg::item_t mem_r [DEPTH];
  logic [IW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  assign pop       = cnt_r != '0;
  assign pop_valid = pop;
  assign full      = cnt_r == CW'(DEPTH);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/gsw_back.sv
module gsw_back #(
  parameter int DIST_FRAC_BITS = gsw_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  gsw_pkg::item_t     pop_item,
  input  logic [31:0]        inv_spacing,
  output logic               out_strobe,
  output logic [15:0]        out_weight,
  output logic signed [31:0] out_grad_x,
  output logic signed [31:0] out_grad_y,
  output logic signed [31:0] out_grad_z,
  output logic               out_last_out
);

  localparam int N       = gsw_pkg::NUM_AXES;
  localparam int SH      = 2 * DIST_FRAC_BITS - 16;
  localparam int HALF    = (1 << SH) >> 1;
  localparam int W_INNER = 7 << (2 * DIST_FRAC_BITS - 3);

  logic [5:0] v_r, v_nxt;
  logic [5:0] node_r;
  logic [5:0] last_r;

  gsw_pkg::region_t reg1_r [N];
  logic [31:0] sq1_r    [N];
  logic [15:0] wmid1_r  [N];
  logic [16:0] gmag1_r  [N];
  logic        gneg1_r  [N];

  logic [15:0] w2_r     [N];
  logic [15:0] w2_nxt   [N];
  logic [16:0] gmag2_r  [N];
  logic        gneg2_r  [N];
  logic [31:0] wex      [N];

  logic [31:0] pxy3_r;
  logic [32:0] g3_r     [N];
  logic [15:0] sy3_r, sz3_r;
  logic        gneg3_r  [N];

  logic [47:0] wp4_r;
  logic [47:0] g4_r     [N];
  logic        gneg4_r  [N];

  logic [15:0] w5_r;
  logic [16:0] m1_5_r   [N];
  logic        gneg5_r  [N];

  logic [15:0] w6_r;
  logic [48:0] mp6_r    [N];
  logic        gneg6_r  [N];

  logic [33:0] m2       [N];
  logic [31:0] g_nxt    [N];
  logic [15:0] w_out_nxt;

  logic [15:0] weight_r;
  logic [31:0] grad_r   [N];
  logic        strobe_r;
  logic        last_out_r;

  assign v_nxt = {v_r[4:0], pop_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      strobe_r <= 1'b0;
    end else begin
      v_r      <= v_nxt;
      strobe_r <= v_r[5];
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      wex[i] = '0;
      unique case (reg1_r[i])
        gsw_pkg::REG_INNER: wex[i] = 32'(W_INNER) - (sq1_r[i] << 1);
        gsw_pkg::REG_OUTER: wex[i] = sq1_r[i];
        gsw_pkg::REG_MID,
        gsw_pkg::REG_ZERO:  wex[i] = '0;
      endcase
      if (reg1_r[i] == gsw_pkg::REG_MID) begin
        w2_nxt[i] = wmid1_r[i];
      end else begin
        w2_nxt[i] = 16'((wex[i] + 32'(HALF)) >> SH);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      m2[i] = 34'((50'(mp6_r[i]) + 50'(1 << 15)) >> 16);
      if (!gneg6_r[i]) begin
        g_nxt[i] = (m2[i] > 34'h07FFFFFFF) ? 32'h7FFFFFFF : m2[i][31:0];
      end else begin
        g_nxt[i] = (m2[i] >= 34'h080000000) ? 32'h80000000 : 32'(~m2[i][31:0] + 32'd1);
      end
      if (!node_r[5]) begin
        g_nxt[i] = '0;
      end
    end
    w_out_nxt = node_r[5] ? w6_r : 16'd0;
  end

  always_ff @(posedge clk) begin
    node_r <= {node_r[4:0], pop_item.node_valid};
    last_r <= {last_r[4:0], pop_item.last};

    for (int i = 0; i < N; i++) begin
      reg1_r[i]  <= pop_item.ax[i].region;
      sq1_r[i]   <= 32'(pop_item.ax[i].sq_op) * 32'(pop_item.ax[i].sq_op);
      wmid1_r[i] <= pop_item.ax[i].w_mid;
      gmag1_r[i] <= pop_item.ax[i].gmag;
      gneg1_r[i] <= pop_item.ax[i].gneg;

      w2_r[i]    <= w2_nxt[i];
      gmag2_r[i] <= gmag1_r[i];
      gneg2_r[i] <= gneg1_r[i];

      gneg3_r[i] <= gneg2_r[i];
      gneg4_r[i] <= gneg3_r[i];
      gneg5_r[i] <= gneg4_r[i];
      gneg6_r[i] <= gneg5_r[i];

      m1_5_r[i]  <= 17'((49'(g4_r[i]) + 49'(64'd1 << 31)) >> 32);
      mp6_r[i]   <= 49'(m1_5_r[i]) * 49'(inv_spacing);
      grad_r[i]  <= g_nxt[i];
    end

    pxy3_r  <= 32'(w2_r[0]) * 32'(w2_r[1]);
    g3_r[0] <= 33'(gmag2_r[0]) * 33'(w2_r[1]);
    g3_r[1] <= 33'(gmag2_r[1]) * 33'(w2_r[0]);
    g3_r[2] <= 33'(gmag2_r[2]) * 33'(w2_r[0]);
    sy3_r   <= w2_r[1];
    sz3_r   <= w2_r[2];

    wp4_r   <= 48'(pxy3_r) * 48'(sz3_r);
    g4_r[0] <= 48'(g3_r[0]) * 48'(sz3_r);
    g4_r[1] <= 48'(g3_r[1]) * 48'(sz3_r);
    g4_r[2] <= 48'(g3_r[2]) * 48'(sy3_r);

    w5_r       <= 16'((49'(wp4_r) + 49'(64'd1 << 31)) >> 32);
    w6_r       <= w5_r;
    weight_r   <= w_out_nxt;
    last_out_r <= last_r[5];
  end

  assign out_strobe   = strobe_r;
  assign out_weight   = weight_r;
  assign out_grad_x   = grad_r[0];
  assign out_grad_y   = grad_r[1];
  assign out_grad_z   = grad_r[2];
  assign out_last_out = last_out_r;

endmodule

### hw/rtl/gimp_shape_weight_gradient.sv
// One node offset is taken per clock whenever start is high and busy is low, and its
// result appears on the out_ ports, marked by out_strobe for one cycle; the receiver
// cannot stall, so the back pipeline never stops and takes an entry from the two-entry
// queue between the classifying front end and the multiplier pipeline in every cycle in
// which the queue holds one; the queue never holds more than one entry, and busy
// stays low. Sustained rate is one beat per cycle, set by the seven-stage arithmetic
// pipeline of squares, products and scaling, which accepts a new beat every cycle.
// Write inv_spacing through cfg_we and cfg_wdata only while no beat is in flight.
module gimp_shape_weight_gradient #(
  parameter int DIST_FRAC_BITS = gsw_pkg::DIST_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH    = gsw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_dist_x,
  input  logic signed [15:0] in_dist_y,
  input  logic signed [15:0] in_dist_z,
  input  logic               in_node_valid,
  input  logic               in_last_node,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               out_strobe,
  output logic [15:0]        out_weight,
  output logic signed [31:0] out_grad_x,
  output logic signed [31:0] out_grad_y,
  output logic signed [31:0] out_grad_z,
  output logic               out_last_out
);

  logic           q_full;
  logic           push;
  gsw_pkg::item_t push_item;
  logic           pop_valid;
  gsw_pkg::item_t pop_item;
  logic [31:0]    inv_spacing_r, inv_spacing_nxt;

  assign busy            = q_full;
  assign inv_spacing_nxt = cfg_we ? cfg_wdata : inv_spacing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_spacing_r <= gsw_pkg::INV_SPACING_RST;
    end else begin
      inv_spacing_r <= inv_spacing_nxt;
    end
  end

  gsw_front #(
    .DIST_FRAC_BITS(DIST_FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .q_full        (q_full),
    .in_dist_x     (in_dist_x),
    .in_dist_y     (in_dist_y),
    .in_dist_z     (in_dist_z),
    .in_node_valid (in_node_valid),
    .in_last_node  (in_last_node),
    .push          (push),
    .push_item     (push_item)
  );

  gsw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  gsw_back #(
    .DIST_FRAC_BITS(DIST_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_item     (pop_item),
    .inv_spacing  (inv_spacing_r),
    .out_strobe   (out_strobe),
    .out_weight   (out_weight),
    .out_grad_x   (out_grad_x),
    .out_grad_y   (out_grad_y),
    .out_grad_z   (out_grad_z),
    .out_last_out (out_last_out)
  );

endmodule
